// ----- design/aclm_pkg.sv -----
package aclm_pkg;

  localparam int unsigned LevelW     = 16;
  localparam int unsigned ChanFieldW = 4;
  localparam int unsigned DefChannels = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // Input actions.
  typedef enum logic [1:0] {
    ActSample = 2'd0,
    ActTick   = 2'd1,
    ActClear  = 2'd2,
    ActQuery  = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgClipThr    = 2'd0,
    CfgSilenceThr = 2'd1,
    CfgClipHold   = 2'd2,
    CfgSilenceTo  = 2'd3
  } cfg_idx_e;

  // Channel states.
  localparam logic [1:0] StNormal = 2'd0;
  localparam logic [1:0] StSilent = 2'd1;
  localparam logic [1:0] StClip   = 2'd2;

  // Timer kinds.
  localparam logic [1:0] TmIdle    = 2'd0;
  localparam logic [1:0] TmSilence = 2'd1;
  localparam logic [1:0] TmClip    = 2'd2;

  // Result kinds.
  localparam logic KindEvent = 1'b0;
  localparam logic KindReply = 1'b1;

  // Register reset values.
  localparam logic [LevelW-1:0] RstClipThr    = 16'd65535;
  localparam logic [LevelW-1:0] RstSilenceThr = 16'd64;
  localparam logic [LevelW-1:0] RstClipHold   = 16'd1000;
  localparam logic [LevelW-1:0] RstSilenceTo  = 16'd5000;

  // One memory word: the state, timer kind and time left kept per channel.
  typedef struct packed {
    logic [1:0]        st;
    logic [1:0]        tk;
    logic [LevelW-1:0] left;
  } entry_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    CtlIdle   = 5'b00001,
    CtlSample = 5'b00010,
    CtlQuery  = 5'b00100,
    CtlScan   = 5'b01000,
    CtlFlush  = 5'b10000
  } ctl_e;

endpackage

// ----- design/audio_channel_level_monitor_top.sv -----
// A sample or query result is loaded into the output register from the Sample or Query state
// that follows acceptance; a tick's results are loaded during its scan and its final result
// from the Flush state after the scan. Output stalls can hold any of these states.
// Requests are taken one at a time; clear all, and a sample for a channel out of range, give
// no result and leave the block idle.
// Reset (asynchronous, active low) restores the register defaults and clears the per-entry
// valid bits, so every channel reads as normal with its timer idle; no clearing pass runs.
module audio_channel_level_monitor_top #(
  parameter int unsigned CHANNELS = aclm_pkg::DefChannels
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic [aclm_pkg::ChanFieldW-1:0] channel_i,
  input  logic [aclm_pkg::LevelW-1:0]     level_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            kind_o,
  output logic [aclm_pkg::ChanFieldW-1:0] chan_out_o,
  output logic [1:0]                      new_state_o,
  output logic                            last_o,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [aclm_pkg::LevelW-1:0]     cfg_data_i
);
  import aclm_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [LevelW-1:0] clip_thr_q, sil_thr_q, clip_hold_q, sil_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_thr_q  <= RstClipThr;
      sil_thr_q   <= RstSilenceThr;
      clip_hold_q <= RstClipHold;
      sil_to_q    <= RstSilenceTo;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgClipThr:    clip_thr_q  <= cfg_data_i;
        CfgSilenceThr: sil_thr_q   <= cfg_data_i;
        CfgClipHold:   clip_hold_q <= cfg_data_i;
        CfgSilenceTo:  sil_to_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Channel state memory. Each word has a valid bit in flip-flops; a word that is not valid
  // reads as the reset value, so reset and clear all just drop the valid bits.
  entry_t            mem_q [CHANNELS];
  entry_t            rdata_q;
  logic              rvld_q;
  logic [CHANNELS-1:0] vld_q;
  logic              mem_we, mem_re, clear_all;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  entry_t            mem_wdata;
  entry_t            rd_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // The valid bit is sampled together with the read data so the pair stays consistent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_re) begin
        rvld_q <= vld_q[mem_raddr];
      end
      if (clear_all) begin
        vld_q <= '0;
      end else if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  assign rd_entry = rvld_q ? rdata_q : '0;

  // Sequencer and request registers.
  ctl_e                  ctl_q, ctl_d;
  logic [ChanFieldW-1:0] chan_q;
  logic [LevelW-1:0]     level_q;
  logic                  in_range_q;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  // A tick can raise several events. The newest one waits in a pending register until either
  // another event pushes it out (not last) or the scan ends (last).
  logic                  pend_vld_q, pend_vld_d;
  logic [ChanFieldW-1:0] pend_chan_q, pend_chan_d;
  logic [1:0]            pend_st_q, pend_st_d;

  // Output register.
  logic                  out_vld_q;
  logic                  out_kind_q, out_last_q;
  logic [ChanFieldW-1:0] out_chan_q;
  logic [1:0]            out_st_q;
  logic                  out_free;
  logic                  push, push_kind, push_last;
  logic [ChanFieldW-1:0] push_chan;
  logic [1:0]            push_st;

  logic                  accept, chan_ok;

  assign in_stall_o = (ctl_q != CtlIdle);
  assign accept     = in_valid_i && (ctl_q == CtlIdle);
  assign chan_ok    = ({3'b000, channel_i} < 7'(CHANNELS));
  assign out_free   = !out_vld_q || !out_stall_i;

  // Sample update on the word read for chan_q.
  entry_t smp_entry;
  logic   smp_evt;

  always_comb begin
    smp_entry = rd_entry;
    smp_evt   = 1'b0;
    if (level_q >= clip_thr_q) begin
      smp_evt        = (rd_entry.st != StClip);
      smp_entry.st   = StClip;
      smp_entry.tk   = TmClip;
      smp_entry.left = clip_hold_q;
    end else if (rd_entry.tk == TmClip) begin
      // Clip hold running: the sample is ignored.
    end else if (level_q <= sil_thr_q) begin
      if ((rd_entry.st != StSilent) && (rd_entry.tk == TmIdle)) begin
        smp_entry.tk   = TmSilence;
        smp_entry.left = sil_to_q;
      end
    end else begin
      smp_evt        = (rd_entry.st != StNormal);
      smp_entry.st   = StNormal;
      smp_entry.tk   = TmIdle;
      smp_entry.left = '0;
    end
  end

  // Tick update on the word read for idx_q.
  entry_t tk_entry;
  logic   tk_evt;

  always_comb begin
    tk_entry = rd_entry;
    tk_evt   = 1'b0;
    if (rd_entry.tk != TmIdle) begin
      if (rd_entry.left > 16'd1) begin
        tk_entry.left = rd_entry.left - 16'd1;
      end else begin
        tk_entry.tk   = TmIdle;
        tk_entry.left = '0;
        tk_entry.st   = (rd_entry.tk == TmClip) ? StNormal : StSilent;
        tk_evt        = (tk_entry.st != rd_entry.st);
      end
    end
  end

  logic tk_keep, tk_stall, scan_end;

  assign tk_keep  = tk_evt && (cnt_q < CntW'(MaxResults));
  assign tk_stall = tk_keep && pend_vld_q && !out_free;
  assign scan_end = (idx_q == IdxW'(CHANNELS - 1));

  always_comb begin
    ctl_d       = ctl_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pend_vld_d  = pend_vld_q;
    pend_chan_d = pend_chan_q;
    pend_st_d   = pend_st_q;
    mem_we      = 1'b0;
    mem_waddr   = IdxW'(chan_q);
    mem_wdata   = smp_entry;
    mem_re      = 1'b0;
    mem_raddr   = IdxW'(channel_i);
    clear_all   = 1'b0;
    push        = 1'b0;
    push_kind   = KindEvent;
    push_chan   = chan_q;
    push_st     = smp_entry.st;
    push_last   = 1'b1;

    unique case (ctl_q)
      CtlIdle: begin
        if (accept) begin
          unique case (action_e'(action_i))
            ActSample: begin
              if (chan_ok) begin
                mem_re = 1'b1;
                ctl_d  = CtlSample;
              end
            end
            ActTick: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_d     = '0;
              cnt_d     = '0;
              ctl_d     = CtlScan;
            end
            ActClear: begin
              clear_all = 1'b1;
            end
            ActQuery: begin
              mem_re = chan_ok;
              ctl_d  = CtlQuery;
            end
            default: ;
          endcase
        end
      end
      CtlSample: begin
        if (!smp_evt || out_free) begin
          mem_we = 1'b1;
          push   = smp_evt;
          ctl_d  = CtlIdle;
        end
      end
      CtlQuery: begin
        push_kind = KindReply;
        push_st   = in_range_q ? rd_entry.st : StNormal;
        if (out_free) begin
          push  = 1'b1;
          ctl_d = CtlIdle;
        end
      end
      CtlScan: begin
        mem_waddr = idx_q;
        mem_wdata = tk_entry;
        push_chan = pend_chan_q;
        push_st   = pend_st_q;
        push_last = 1'b0;
        if (!tk_stall) begin
          mem_we = 1'b1;
          if (tk_keep) begin
            push        = pend_vld_q;
            pend_vld_d  = 1'b1;
            pend_chan_d = ChanFieldW'(idx_q);
            pend_st_d   = tk_entry.st;
            cnt_d       = cnt_q + CntW'(1);
          end
          if (scan_end) begin
            ctl_d = CtlFlush;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_q + IdxW'(1);
            idx_d     = idx_q + IdxW'(1);
          end
        end
      end
      CtlFlush: begin
        push_chan = pend_chan_q;
        push_st   = pend_st_q;
        if (!pend_vld_q) begin
          ctl_d = CtlIdle;
        end else if (out_free) begin
          push       = 1'b1;
          pend_vld_d = 1'b0;
          ctl_d      = CtlIdle;
        end
      end
      default: ctl_d = CtlIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q      <= CtlIdle;
      idx_q      <= '0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      ctl_q      <= ctl_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q     <= channel_i;
      level_q    <= level_i;
      in_range_q <= chan_ok;
    end
    pend_chan_q <= pend_chan_d;
    pend_st_q   <= pend_st_d;
    if (push) begin
      out_kind_q <= push_kind;
      out_chan_q <= push_chan;
      out_st_q   <= push_st;
      out_last_q <= push_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = out_kind_q;
  assign chan_out_o  = out_chan_q;
  assign new_state_o = out_st_q;
  assign last_o      = out_last_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

// Level monitor testbench. A short directed script walks the reset state, the
// clip hold, the silence timeout and clear all. Random traffic then runs under
// several register settings, including the extremes. Each result is checked
// against a local model of channel state and timers, or against one typed in.
module testbench;
  import aclm_pkg::*;

  localparam int unsigned Channels       = DefChannels;
  // A tick scans every channel once, so this settling wait covers any
  // request that is still in flight without producing a result.
  localparam int unsigned SettleCycles   = 2 * Channels + 8;
  localparam int unsigned WatchdogLimit  = 5000;
  localparam int unsigned RandomPerPhase = 64;
  localparam int unsigned ReportedMax    = 10;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    logic                  kind;
    logic [ChanFieldW-1:0] chan;
    logic [1:0]            state;
    logic                  last;
  } report_t;

  // How the results of a directed row are known: from the model, or typed in.
  typedef enum logic [1:0] {
    ByPredictor,
    NoReport,
    OneReport
  } row_check_e;

  typedef struct {
    action_e               act;
    logic [ChanFieldW-1:0] ch;
    logic [LevelW-1:0]     lvl;
    row_check_e            how;
    logic                  kind;
    logic [1:0]            state;
  } stim_row_t;

  // Every input of the block is known from time zero.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [1:0]            action    = ActQuery;
  logic [ChanFieldW-1:0] channel   = '0;
  logic [LevelW-1:0]     level     = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  kind;
  logic [ChanFieldW-1:0] chan_out;
  logic [1:0]            new_state;
  logic                  last;
  logic                  cfg_we    = 1'b0;
  logic [1:0]            cfg_index = CfgClipThr;
  logic [LevelW-1:0]     cfg_data  = '0;

  idle_mode_e idle_mode = IdleNone;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Local copy of the registers and of the per-channel state.
  logic [LevelW-1:0] clip_thr_q = RstClipThr;
  logic [LevelW-1:0] sil_thr_q  = RstSilenceThr;
  logic [LevelW-1:0] hold_q     = RstClipHold;
  logic [LevelW-1:0] timeout_q  = RstSilenceTo;
  logic [1:0]        ch_state [Channels];
  logic [1:0]        tmr_kind [Channels];
  logic [LevelW-1:0] tmr_left [Channels];

  report_t   fresh_reports[$];    // results of the request just accepted
  report_t   awaited_reports[$];  // results still to come from the block
  stim_row_t script[$];

  audio_channel_level_monitor_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .channel_i   (channel),
    .level_i     (level),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .chan_out_o  (chan_out),
    .new_state_o (new_state),
    .last_o      (last),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the monitor.
  // ---------------------------------------------------------------------------

  function automatic void note(logic k, logic [ChanFieldW-1:0] ch, logic [1:0] st);
    report_t r;
    if (fresh_reports.size() < MaxResults) begin
      r.kind  = k;
      r.chan  = ch;
      r.state = st;
      r.last  = 1'b0;
      fresh_reports.push_back(r);
    end
  endfunction

  // An event is raised only when the state really changes.
  function automatic void move_to(int ch, logic [1:0] st);
    if (ch_state[ch] != st) begin
      ch_state[ch] = st;
      note(KindEvent, ch[ChanFieldW-1:0], st);
    end
  endfunction

  function automatic void advance_levels(action_e act, logic [ChanFieldW-1:0] ch,
                                         logic [LevelW-1:0] lvl);
    logic [1:0] tk;
    report_t    r;
    fresh_reports.delete();
    case (act)
      ActSample: begin
        if (lvl >= clip_thr_q) begin
          // A clipping sample (re)starts the hold and drops any silence timeout.
          move_to(ch, StClip);
          tmr_kind[ch] = TmClip;
          tmr_left[ch] = hold_q;
        end else if (tmr_kind[ch] != TmClip) begin
          if (lvl <= sil_thr_q) begin
            if (ch_state[ch] != StSilent && tmr_kind[ch] == TmIdle) begin
              tmr_kind[ch] = TmSilence;
              tmr_left[ch] = timeout_q;
            end
          end else begin
            tmr_kind[ch] = TmIdle;
            tmr_left[ch] = '0;
            move_to(ch, StNormal);
          end
        end
      end
      ActTick: begin
        for (int c = 0; c < Channels; c++) begin
          tk = tmr_kind[c];
          if (tk != TmIdle) begin
            if (tmr_left[c] > 1) begin
              tmr_left[c] = tmr_left[c] - 1'b1;
            end else begin
              tmr_kind[c] = TmIdle;
              tmr_left[c] = '0;
              move_to(c, (tk == TmClip) ? StNormal : StSilent);
            end
          end
        end
      end
      ActClear: begin
        for (int c = 0; c < Channels; c++) begin
          ch_state[c] = StNormal;
          tmr_kind[c] = TmIdle;
          tmr_left[c] = '0;
        end
      end
      default: begin
        note(KindReply, ch, ch_state[ch]);
      end
    endcase
    if (fresh_reports.size() > 0) begin
      r = fresh_reports[fresh_reports.size() - 1];
      r.last = 1'b1;
      fresh_reports[fresh_reports.size() - 1] = r;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  function automatic bit sender_pauses();
    return (idle_mode == IdleSender && $urandom_range(0, 99) < 63) ||
           (idle_mode == IdleBoth && $urandom_range(0, 99) < 38);
  endfunction

  // Offers one request, holds it until accepted, then records what it should
  // produce: the model's results, the single result typed in, or none.
  task automatic send(action_e act, logic [ChanFieldW-1:0] ch, logic [LevelW-1:0] lvl,
                      row_check_e how, logic k, logic [1:0] st);
    while (sender_pauses()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    channel  <= ch;
    level    <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_levels(act, ch, lvl);
    case (how)
      ByPredictor: foreach (fresh_reports[i]) awaited_reports.push_back(fresh_reports[i]);
      OneReport:   awaited_reports.push_back(report_t'({k, ch, st, 1'b1}));
      default:     ;
    endcase
  endtask

  // Stops sending until every awaited result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [LevelW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CfgClipThr:    clip_thr_q = val;
      CfgSilenceThr: sil_thr_q  = val;
      CfgClipHold:   hold_q     = val;
      default:       timeout_q  = val;
    endcase
  endtask

  // Registers change only while the block is idle. A clear or a quiet tick
  // gives no result, so the block may still be busy after the last result.
  task automatic load_registers(logic [LevelW-1:0] clip_thr, logic [LevelW-1:0] sil_thr,
                                logic [LevelW-1:0] hold, logic [LevelW-1:0] timeout);
    drain();
    repeat (SettleCycles) @(posedge clk);
    write_reg(CfgClipThr, clip_thr);
    write_reg(CfgSilenceThr, sil_thr);
    write_reg(CfgClipHold, hold);
    write_reg(CfgSilenceTo, timeout);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(action_e act, logic [ChanFieldW-1:0] ch, logic [LevelW-1:0] lvl,
                         row_check_e how, logic k, logic [1:0] st);
    stim_row_t row;
    row.act   = act;
    row.ch    = ch;
    row.lvl   = lvl;
    row.how   = how;
    row.kind  = k;
    row.state = st;
    script.push_back(row);
  endtask

  task automatic walk_script();
    foreach (script[i]) begin
      send(script[i].act, script[i].ch, script[i].lvl, script[i].how, script[i].kind,
           script[i].state);
    end
    script.delete();
  endtask

  // Drives every channel into clip hold, then ticks: with a short hold this
  // releases all channels on one tick, the largest burst of results.
  task automatic clip_burst();
    for (int c = 0; c < Channels; c++) begin
      send(ActSample, c[ChanFieldW-1:0], '1, ByPredictor, KindEvent, StNormal);
    end
    send(ActTick, '0, '0, ByPredictor, KindEvent, StNormal);
  endtask

  task automatic random_traffic(int count);
    int                    sent;
    int                    pick;
    action_e               act;
    logic [ChanFieldW-1:0] ch;
    logic [LevelW-1:0]     lvl;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        clip_burst();
        sent += Channels + 1;
      end else if (pick < 4) begin
        drain();
      end else begin
        if (pick < 52) begin
          act = ActSample;
        end else if (pick < 80) begin
          act = ActTick;
        end else if (pick < 96) begin
          act = ActQuery;
        end else begin
          act = ActClear;
        end
        // Half the traffic stays on a few channels so that timers get to run out.
        if ($urandom_range(0, 1) != 0) begin
          ch = ChanFieldW'($urandom_range(0, 3));
        end else begin
          ch = ChanFieldW'($urandom_range(0, Channels - 1));
        end
        // Levels spread, near the clip threshold, up to the silence one or between.
        case ($urandom_range(0, 3))
          0:       lvl = LevelW'($urandom());
          1:       lvl = clip_thr_q + LevelW'($urandom_range(0, 4)) - LevelW'(2);
          2:       lvl = LevelW'($urandom_range(0, sil_thr_q));
          default: lvl = LevelW'($urandom_range(sil_thr_q, clip_thr_q));
        endcase
        send(act, ch, lvl, ByPredictor, KindEvent, StNormal);
        sent++;
      end
    end
  endtask

  task automatic run_phase(idle_mode_e mode, logic [LevelW-1:0] clip_thr,
                           logic [LevelW-1:0] sil_thr, logic [LevelW-1:0] hold,
                           logic [LevelW-1:0] timeout, bit burst_first);
    load_registers(clip_thr, sil_thr, hold, timeout);
    idle_mode = mode;
    if (burst_first) clip_burst();
    random_traffic(RandomPerPhase);
  endtask

  // ---------------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    case (idle_mode)
      IdleReceiver: out_stall <= ($urandom_range(0, 99) < 63);
      IdleBoth:     out_stall <= ($urandom_range(0, 99) < 38);
      default:      out_stall <= 1'b0;
    endcase
  end

  // Each accepted result is matched against the oldest awaited one.
  always @(posedge clk) begin
    report_t seen;
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {kind, chan_out, new_state, last};
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportedMax) begin
          $display("%0t: unexpected result kind=%0d chan=%0d state=%0d last=%0d",
                   $time, seen.kind, seen.chan, seen.state, seen.last);
        end
      end else begin
        want = awaited_reports.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= ReportedMax) begin
            $display("%0t: result mismatch: expected kind=%0d chan=%0d state=%0d last=%0d",
                     $time, want.kind, want.chan, want.state, want.last);
            $display("%0t:                  actual   kind=%0d chan=%0d state=%0d last=%0d",
                     $time, seen.kind, seen.chan, seen.state, seen.last);
          end
        end
      end
    end
  end

  // Ends a hung run: too long without a request or a result being accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------

  initial begin
    for (int c = 0; c < Channels; c++) begin
      ch_state[c] = StNormal;
      tmr_kind[c] = TmIdle;
      tmr_left[c] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: only a full-scale sample clips, and the timers are far
    // too long to run out here.
    add_row(ActQuery,  4'd0,  16'd0,     OneReport,   KindReply, StNormal);
    add_row(ActQuery,  4'd15, 16'd0,     OneReport,   KindReply, StNormal);
    add_row(ActSample, 4'd3,  16'hFFFF,  OneReport,   KindEvent, StClip);
    // Quiet sample during the clip hold is ignored.
    add_row(ActSample, 4'd3,  16'd0,     NoReport,    KindEvent, StNormal);
    add_row(ActQuery,  4'd3,  16'd0,     OneReport,   KindReply, StClip);
    // Quiet samples arm the silence timeout once; a second one leaves it alone.
    add_row(ActSample, 4'd5,  16'd0,     NoReport,    KindEvent, StNormal);
    add_row(ActSample, 4'd5,  16'd64,    NoReport,    KindEvent, StNormal);
    add_row(ActSample, 4'd5,  16'hFFFE,  ByPredictor, KindEvent, StNormal);
    add_row(ActTick,   4'd0,  16'd0,     ByPredictor, KindEvent, StNormal);
    add_row(ActClear,  4'd9,  16'h5A5A,  NoReport,    KindEvent, StNormal);
    add_row(ActQuery,  4'd3,  16'd0,     OneReport,   KindReply, StNormal);
    walk_script();

    // Zero hold and a one-tick timeout: both expire on the next tick, and
    // that tick reports them in ascending channel order.
    load_registers(16'h8000, 16'h0100, 16'd0, 16'd1);
    add_row(ActSample, 4'd0,  16'h8000,  ByPredictor, KindEvent, StNormal);
    add_row(ActSample, 4'd1,  16'h0100,  ByPredictor, KindEvent, StNormal);
    add_row(ActSample, 4'd2,  16'h0000,  ByPredictor, KindEvent, StNormal);
    add_row(ActSample, 4'd2,  16'h7FFF,  ByPredictor, KindEvent, StNormal);
    add_row(ActTick,   4'd0,  16'd0,     ByPredictor, KindEvent, StNormal);
    add_row(ActSample, 4'd1,  16'h00FF,  ByPredictor, KindEvent, StNormal);
    add_row(ActQuery,  4'd1,  16'd0,     ByPredictor, KindEvent, StNormal);
    add_row(ActSample, 4'd1,  16'h0101,  ByPredictor, KindEvent, StNormal);
    add_row(ActSample, 4'd0,  16'hFFFF,  ByPredictor, KindEvent, StNormal);
    add_row(ActSample, 4'd0,  16'hFFFF,  ByPredictor, KindEvent, StNormal);
    add_row(ActTick,   4'd0,  16'd0,     ByPredictor, KindEvent, StNormal);
    add_row(ActQuery,  4'd0,  16'd0,     ByPredictor, KindEvent, StNormal);
    walk_script();

    // Random traffic under several settings; the second and third use the
    // register extremes (all but full scale quiet, every sample clipping).
    run_phase(IdleNone,     16'hC000, 16'h0800, 16'd3,     16'd4,     1'b0);
    run_phase(IdleSender,   16'hFFFF, 16'hFFFF, 16'd0,     16'd0,     1'b1);
    run_phase(IdleReceiver, 16'h0000, 16'h0000, 16'hFFFF,  16'hFFFF,  1'b0);
    run_phase(IdleBoth,     16'h9000, 16'h2000, 16'd2,     16'd5,     1'b0);
    run_phase(IdleBoth,     16'h4000, 16'h4000, 16'd6,     16'd1,     1'b0);

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
